[hw/rtl/sswarq_pkg.sv]
// Shared types and constants for the session sliding-window ARQ core.
package sswarq_pkg;

  localparam int WINDOW_SLOTS = 8;
  localparam int EVENT_DEPTH  = 8;
  localparam int HEADER_BYTES = 8;
  localparam int SLOT_W  = $clog2(WINDOW_SLOTS);
  localparam int EVT_W   = $clog2(EVENT_DEPTH);

  localparam logic [3:0] OP_OPEN       = 4'd0;
  localparam logic [3:0] OP_CLOSE      = 4'd1;
  localparam logic [3:0] OP_SEND       = 4'd2;
  localparam logic [3:0] OP_TICK       = 4'd3;
  localparam logic [3:0] OP_RX_DATA    = 4'd4;
  localparam logic [3:0] OP_RX_ACK     = 4'd5;
  localparam logic [3:0] OP_RX_OPENED  = 4'd6;
  localparam logic [3:0] OP_RX_CLOSED  = 4'd7;
  localparam logic [3:0] OP_RX_ERROR   = 4'd8;
  localparam logic [3:0] OP_RX_TIMEOUT = 4'd9;
  localparam logic [3:0] OP_READ_EVENT = 4'd10;

  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_SEND   = 3'd1;
  localparam logic [2:0] ACT_RESEND = 3'd2;
  localparam logic [2:0] ACT_ACK    = 3'd3;
  localparam logic [2:0] ACT_REJECT = 3'd4;
  localparam logic [2:0] ACT_FULL   = 3'd5;
  localparam logic [2:0] ACT_OPEN   = 3'd6;
  localparam logic [2:0] ACT_CLOSE  = 3'd7;

  localparam logic [2:0] ST_UNUSED  = 3'd0;
  localparam logic [2:0] ST_OPENING = 3'd1;
  localparam logic [2:0] ST_OPEN    = 3'd2;
  localparam logic [2:0] ST_CLOSED  = 3'd3;
  localparam logic [2:0] ST_ERROR   = 3'd4;

  localparam logic [1:0] EVT_NONE    = 2'd0;
  localparam logic [1:0] EVT_CLOSED  = 2'd1;
  localparam logic [1:0] EVT_ERROR   = 2'd2;
  localparam logic [1:0] EVT_TIMEOUT = 2'd3;

  localparam logic [0:0] CFG_RETRANSMIT = 1'd0;
  localparam logic [0:0] CFG_MAX_DGRAM  = 1'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       start;  // execute the captured transaction
    logic       load;   // capture the input transaction
  } sswarq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_valid;
  } sswarq_sts_t;

endpackage

[hw/rtl/sswarq_ctrl.sv]
// Controller state machine: sequences capture, execute and result hand-off.
module sswarq_ctrl
  import sswarq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        out_stall,
  output sswarq_cmd_t cmd,
  input  sswarq_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   result_free;

  // The result register is free when empty or being drained this cycle.
  assign result_free = !sts.out_valid || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (result_free) begin
          cmd.start = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (result_free) begin
          cmd.start = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("controller state not one-hot");
  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == S_IDLE) else $error("load outside idle");
  a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> result_free) else $error("result overwritten");

endmodule

[hw/rtl/sswarq_dp.sv]
// Datapath: session counters, window slots, event queue and result register.
module sswarq_dp
  import sswarq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  sswarq_cmd_t cmd,
  output sswarq_sts_t sts,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic [3:0]  in_operation,
  input  logic [15:0] in_sequence_req,
  input  logic [10:0] in_payload_length,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [2:0]  out_action,
  output logic [15:0] out_seq_out,
  output logic [SLOT_W-1:0] out_slot_index,
  output logic        out_deliver,
  output logic [1:0]  out_event_kind,
  output logic [2:0]  out_conn_state,
  output logic        out_event_overflow,
  output logic [31:0] out_session_number
);

  logic [15:0] rtx_ticks_r;
  logic [10:0] max_dgram_r;
  logic [3:0]  op_r;
  logic [15:0] seq_r;
  logic [10:0] len_r;

  logic [2:0]  link_r, link_nxt;
  logic [31:0] sess_r, sess_nxt;
  logic [15:0] base_r, base_nxt;
  logic [15:0] nseq_r, nseq_nxt;
  logic [15:0] exp_r, exp_nxt;
  logic [WINDOW_SLOTS-1:0] busy_r, busy_nxt;
  logic [31:0] stamp_r [WINDOW_SLOTS];
  logic [31:0] tick_r, tick_nxt;
  logic [1:0]  evq_r [EVENT_DEPTH];
  logic [EVT_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic        ovf_r, ovf_nxt;

  logic        stamp_we;
  logic [SLOT_W-1:0] stamp_idx;
  logic [31:0] stamp_val;
  logic        evq_we;
  logic [1:0]  evq_val;

  logic [2:0]  act;
  logic [15:0] sq;
  logic [SLOT_W-1:0] slot;
  logic        dlv;
  logic [1:0]  kind;

  logic        used;
  logic [15:0] in_flight, adv;
  logic [11:0] need_len;
  logic [SLOT_W-1:0] base_slot, nseq_slot, ack_slot;
  logic [31:0] tick_inc;
  logic [EVT_W-1:0] tail_inc;

  always_comb begin
    used      = link_r != ST_UNUSED;
    in_flight = nseq_r - base_r;
    adv       = seq_r - base_r;
    need_len  = 12'(HEADER_BYTES) + {1'b0, len_r};
    base_slot = base_r[SLOT_W-1:0];
    nseq_slot = nseq_r[SLOT_W-1:0];
    tick_inc  = tick_r + 32'd1;
    tail_inc  = tail_r + 1'b1;

    link_nxt = link_r; sess_nxt = sess_r; base_nxt = base_r; nseq_nxt = nseq_r;
    exp_nxt = exp_r; busy_nxt = busy_r; tick_nxt = tick_r;
    head_nxt = head_r; tail_nxt = tail_r; ovf_nxt = ovf_r;
    stamp_we = 1'b0; stamp_idx = nseq_slot; stamp_val = tick_r;
    evq_we = 1'b0; evq_val = EVT_NONE;
    act = ACT_NONE; sq = '0; slot = '0; dlv = 1'b0; kind = EVT_NONE;
    ack_slot = '0;

    case (op_r)
      OP_OPEN: begin
        sess_nxt = sess_r + 32'd1; link_nxt = ST_OPENING;
        base_nxt = '0; nseq_nxt = '0; exp_nxt = '0; busy_nxt = '0;
        head_nxt = '0; tail_nxt = '0; ovf_nxt = 1'b0; act = ACT_OPEN;
      end
      OP_CLOSE: begin
        if (used) begin
          link_nxt = ST_UNUSED; act = ACT_CLOSE;
        end else begin
          act = ACT_REJECT;
        end
      end
      OP_SEND: begin
        if (!used || need_len > {1'b0, max_dgram_r} || link_r != ST_OPEN) begin
          act = ACT_REJECT;
        end else if (in_flight >= 16'(WINDOW_SLOTS)) begin
          act = ACT_FULL;
        end else begin
          busy_nxt[nseq_slot] = 1'b1;
          stamp_we = 1'b1;
          act = ACT_SEND; sq = nseq_r; slot = nseq_slot;
          nseq_nxt = nseq_r + 16'd1;
        end
      end
      OP_TICK: begin
        tick_nxt = tick_inc;
        if (link_r == ST_OPEN && in_flight != 16'd0 && busy_r[base_slot] &&
            (tick_inc - stamp_r[base_slot]) >= {16'd0, rtx_ticks_r}) begin
          stamp_we = 1'b1; stamp_idx = base_slot; stamp_val = tick_inc;
          act = ACT_RESEND; sq = base_r; slot = base_slot;
        end
      end
      OP_RX_DATA: begin
        if (used) begin
          if (seq_r == exp_r) begin
            exp_nxt = exp_r + 16'd1; dlv = 1'b1;
          end
          act = ACT_ACK; sq = exp_nxt;
        end
      end
      OP_RX_ACK: begin
        if (used && adv != 16'd0 && adv <= in_flight) begin
          // Advance is at most the in-flight count, so at most WINDOW_SLOTS.
          for (int i = 0; i < WINDOW_SLOTS; i++) begin
            ack_slot = base_slot + SLOT_W'(i);
            if (16'(i) < adv) busy_nxt[ack_slot] = 1'b0;
          end
          base_nxt = seq_r;
        end
      end
      OP_RX_OPENED: if (used) link_nxt = ST_OPEN;
      OP_RX_CLOSED, OP_RX_ERROR, OP_RX_TIMEOUT: begin
        if (used) begin
          link_nxt = (op_r == OP_RX_CLOSED) ? ST_CLOSED : ST_ERROR;
          evq_we = 1'b1;
          evq_val = (op_r == OP_RX_CLOSED) ? EVT_CLOSED :
                    (op_r == OP_RX_ERROR) ? EVT_ERROR : EVT_TIMEOUT;
          if (tail_inc == head_r) begin
            head_nxt = head_r + 1'b1; ovf_nxt = 1'b1;
          end
          tail_nxt = tail_inc;
        end
      end
      OP_READ_EVENT: begin
        if (used && head_r != tail_r) begin
          kind = evq_r[head_r]; head_nxt = head_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_operation; seq_r <= in_sequence_req; len_r <= in_payload_length;
    end
    if (cmd.start && stamp_we) stamp_r[stamp_idx] <= stamp_val;
    if (cmd.start && evq_we) evq_r[tail_r] <= evq_val;
    if (cmd.start) begin
      out_action <= act; out_seq_out <= sq; out_slot_index <= slot;
      out_deliver <= dlv; out_event_kind <= kind; out_conn_state <= link_nxt;
      out_event_overflow <= ovf_nxt; out_session_number <= sess_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rtx_ticks_r <= 16'd100; max_dgram_r <= 11'd1400;
      link_r <= ST_UNUSED; sess_r <= '0; base_r <= '0; nseq_r <= '0;
      exp_r <= '0; busy_r <= '0; tick_r <= '0; head_r <= '0; tail_r <= '0;
      ovf_r <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_RETRANSMIT) rtx_ticks_r <= cfg_wdata;
      if (cfg_we && cfg_index == CFG_MAX_DGRAM)  max_dgram_r <= cfg_wdata[10:0];
      if (cmd.start) begin
        link_r <= link_nxt; sess_r <= sess_nxt; base_r <= base_nxt;
        nseq_r <= nseq_nxt; exp_r <= exp_nxt; busy_r <= busy_nxt;
        tick_r <= tick_nxt; head_r <= head_nxt; tail_r <= tail_nxt;
        ovf_r <= ovf_nxt;
      end
      if (cmd.start)           out_valid <= 1'b1;
      else if (!out_stall)     out_valid <= 1'b0;
    end
  end

  assign sts.out_valid = out_valid;

  a_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    (nseq_r - base_r) <= 16'(WINDOW_SLOTS)) else $error("window overrun");
  a_busy_base: assert property (@(posedge clk) disable iff (!rst_n)
    (nseq_r == base_r) |-> busy_r == '0) else $error("busy slot with empty window");
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (ovf_r && !(cmd.start && op_r == OP_OPEN)) |=> ovf_r) else $error("overflow lost");

endmodule

[hw/rtl/session_sliding_window_arq_core.sv]
// Top level of the session sliding-window ARQ core.
// Usage: one connection's sequencing controller. Each input transaction
// (operation, sequence_req, payload_length) yields exactly one result
// transaction (action, seq_out, slot_index, deliver, event_kind, conn_state,
// event_overflow, session_number), in order.
// Both channels use valid/stall handshakes; a transaction moves at a clock
// edge where valid is high and stall is low.
// The accepting edge captures an input; its execution then writes the result
// into the output register, once that register is free.
// The controller captures an item, then executes it against the single set
// of session registers; it accepts no new item until that item has executed.
// While the receiver stalls, the finished result holds in the output
// register; the next item may still be captured, and waits until the
// output register frees before it executes.
// Reset (rst_n low, synchronous) clears the session state, the event queue
// pointers and the busy mask, and loads retransmit_ticks = 100 and
// max_datagram = 1400. No clearing pass is needed.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once; the
// user must make them only while the block is idle: the block does not enforce it.
module session_sliding_window_arq_core
  import sswarq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_operation,
  input  logic [15:0] in_sequence_req,
  input  logic [10:0] in_payload_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_action,
  output logic [15:0] out_seq_out,
  output logic [2:0]  out_slot_index,
  output logic        out_deliver,
  output logic [1:0]  out_event_kind,
  output logic [2:0]  out_conn_state,
  output logic        out_event_overflow,
  output logic [31:0] out_session_number
);

  sswarq_cmd_t cmd;
  sswarq_sts_t sts;

  sswarq_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_stall, .cmd, .sts
  );

  sswarq_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .cfg_we, .cfg_index, .cfg_wdata,
    .in_operation, .in_sequence_req, .in_payload_length, .out_stall,
    .out_valid, .out_action, .out_seq_out, .out_slot_index, .out_deliver,
    .out_event_kind, .out_conn_state, .out_event_overflow, .out_session_number
  );

endmodule
